// ----- rtl/core/pbt_pkg.sv -----
// ============================================================================
// pbt_pkg: shared types and constants of the proximity baseline tracker
// Field widths, the register map and the configuration and lane control types.
// ============================================================================
package pbt_pkg;

  localparam int READ_W   = 20;
  localparam int REPORT_W = 15;
  localparam int COUNT_W  = 8;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [REPORT_W-1:0] REPORT_MAX = {REPORT_W{1'b1}};

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_RISE_SPAN        = 2'd0;
  localparam logic [1:0] REG_PEAK_WINDOW      = 2'd1;
  localparam logic [1:0] REG_NEGATIVE_LIMIT   = 2'd2;
  localparam logic [1:0] REG_CHANGE_TOLERANCE = 2'd3;

  localparam logic [7:0]         RISE_SPAN_RST        = 8'd50;
  localparam logic [7:0]         PEAK_WINDOW_RST      = 8'd2;
  localparam logic signed [15:0] NEGATIVE_LIMIT_RST   = -16'sd30;
  localparam logic [7:0]         CHANGE_TOLERANCE_RST = 8'd5;

  typedef struct packed {
    logic [7:0]         rise_span;
    logic [7:0]         peak_window;
    logic signed [15:0] negative_limit;
    logic [7:0]         change_tolerance;
  } pbt_cfg_t;

  // Per-cycle control that the top level hands to every lane.
  typedef struct packed {
    logic accept;   // a request enters the first stage this cycle
    logic in_load;  // the entering request is a baseline load
    logic fire;     // the first stage moves into the output register
    logic s1_load;  // the first stage holds a baseline load
  } pbt_lane_ctrl_t;

endpackage

// ----- rtl/core/proximity_baseline_tracker_top.sv -----
// ============================================================================
// proximity_baseline_tracker_top: two-channel capacitive proximity tracker
// Baseline tracking, proximity report and change flag for channels A and B.
// ============================================================================
// Usage. Requests arrive on the in_ channel (in_valid, in_stall, in_kind,
// in_value_a, in_value_b) and are accepted at a clock edge with in_valid high
// and in_stall low. A kind 0 request carries one reading per channel; a
// kind 1 request loads both baselines and returns the previous reports with
// out_changed low. Every request yields exactly one result on the out_
// channel, taken at an edge with out_valid high and out_stall low.
// A request passes the history and running sum stage, then the baseline
// update into the output register. Throughput is one request per cycle
// while out_stall is low, since each lane finishes its baseline update before
// the next request reaches it. While the receiver stalls, the output register
// holds its result and the first stage still takes one more request; in_stall
// rises only when both are full. Synchronous active-low reset clears the
// histories, baselines, peaks, window counts and last reports and restores the
// register defaults (rise span 50, peak window 2, negative limit -30, change
// tolerance 5). Registers sit on an APB-style port at byte addresses 0, 4, 8
// and 12. Write them only while no request is in flight; nothing enforces it.
// ============================================================================
module proximity_baseline_tracker_top import pbt_pkg::*; #(
  parameter int HISTORY_DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Input request channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_kind,
  input  logic signed [READ_W-1:0] in_value_a,
  input  logic signed [READ_W-1:0] in_value_b,
  // Result channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [REPORT_W-1:0]      out_proximity_a,
  output logic [REPORT_W-1:0]      out_proximity_b,
  output logic                     out_changed,
  // Configuration port.
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  localparam int SLOT_W = $clog2(HISTORY_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);

  pbt_cfg_t          cfg_r;
  logic              cfg_write;
  logic [1:0]        reg_index;
  logic [SLOT_W-1:0] slot_r;
  logic              s1_valid_r;
  logic              s1_load_r;
  logic              accept;
  logic              fire;
  pbt_lane_ctrl_t    lane_ctrl;
  logic [REPORT_W-1:0] report_a;
  logic [REPORT_W-1:0] report_b;
  logic              changed_a;
  logic              changed_b;

  // ---------------------------------------------------------------------------
  // Configuration registers. pready is tied high, so every access completes in
  // its access cycle. Reads return the raw register bits, zero-extended.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rise_span        <= RISE_SPAN_RST;
      cfg_r.peak_window      <= PEAK_WINDOW_RST;
      cfg_r.negative_limit   <= NEGATIVE_LIMIT_RST;
      cfg_r.change_tolerance <= CHANGE_TOLERANCE_RST;
    end else if (cfg_write) begin
      case (reg_index)
        REG_RISE_SPAN:        cfg_r.rise_span        <= pwdata[7:0];
        REG_PEAK_WINDOW:      cfg_r.peak_window      <= pwdata[7:0];
        REG_NEGATIVE_LIMIT:   cfg_r.negative_limit   <= pwdata[15:0];
        REG_CHANGE_TOLERANCE: cfg_r.change_tolerance <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_RISE_SPAN:        prdata = DATA_W'(cfg_r.rise_span);
      REG_PEAK_WINDOW:      prdata = DATA_W'(cfg_r.peak_window);
      REG_NEGATIVE_LIMIT:   prdata = DATA_W'($unsigned(cfg_r.negative_limit));
      REG_CHANGE_TOLERANCE: prdata = DATA_W'(cfg_r.change_tolerance);
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control. The first stage frees up whenever its request moves into the
  // output register, so a new request can enter in the same cycle.
  // ---------------------------------------------------------------------------
  assign in_stall = s1_valid_r && !fire;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_load_r <= in_kind;
    end
  end

  // The history slot is shared by both channels and advances on measurements.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (accept && !in_kind) begin
      slot_r <= (slot_r == SLOT_LAST) ? '0 : slot_r + SLOT_W'(1);
    end
  end

  always_comb begin
    lane_ctrl.accept  = accept;
    lane_ctrl.in_load = in_kind;
    lane_ctrl.fire    = fire;
    lane_ctrl.s1_load = s1_load_r;
  end

  // ---------------------------------------------------------------------------
  // Two identical lanes, one per channel, and the merge into the result.
  // ---------------------------------------------------------------------------
  pbt_lane #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_lane_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (lane_ctrl),
    .slot    (slot_r),
    .value   (in_value_a),
    .cfg     (cfg_r),
    .report  (report_a),
    .changed (changed_a)
  );

  pbt_lane #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_lane_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (lane_ctrl),
    .slot    (slot_r),
    .value   (in_value_b),
    .cfg     (cfg_r),
    .report  (report_b),
    .changed (changed_b)
  );

  pbt_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .s1_valid        (s1_valid_r),
    .report_a        (report_a),
    .report_b        (report_b),
    .changed_a       (changed_a),
    .changed_b       (changed_b),
    .out_stall       (out_stall),
    .fire            (fire),
    .out_valid       (out_valid),
    .out_proximity_a (out_proximity_a),
    .out_proximity_b (out_proximity_b),
    .out_changed     (out_changed)
  );

endmodule

// ----- rtl/core/pbt_lane.sv -----
// ============================================================================
// pbt_lane: one channel of the proximity baseline tracker
// History and running sum in the first stage; baseline, peak window, report
// and change detection as the request moves to the output register.
// ============================================================================
module pbt_lane import pbt_pkg::*; #(
  parameter int HISTORY_DEPTH = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pbt_lane_ctrl_t                       ctrl,
  input  logic [$clog2(HISTORY_DEPTH)-1:0]     slot,
  input  logic signed [READ_W-1:0]             value,
  input  pbt_cfg_t                             cfg,
  output logic [REPORT_W-1:0]                  report,
  output logic                                 changed
);

  localparam int SUM_W = READ_W + $clog2(HISTORY_DEPTH);
  localparam int TOT_W = SUM_W - 1;
  localparam int CW    = TOT_W + 1;

  logic signed [READ_W-1:0] hist_r [HISTORY_DEPTH];
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [TOT_W-1:0]  s1_val_r;

  logic signed [TOT_W-1:0]  base_r;
  logic signed [TOT_W-1:0]  base_nxt;
  logic signed [TOT_W-1:0]  peak_r;
  logic signed [TOT_W-1:0]  peak_nxt;
  logic [COUNT_W-1:0]       wc_r;
  logic [COUNT_W-1:0]       wc_nxt;
  logic [REPORT_W-1:0]      last_r;

  logic signed [TOT_W-1:0]  peak_cand;
  logic signed [TOT_W-1:0]  base1;
  logic signed [CW-1:0]     tot_w;
  logic signed [CW-1:0]     base_w;
  logic signed [CW-1:0]     base1_w;
  logic signed [CW-1:0]     peak_w;
  logic signed [CW-1:0]     diff;
  logic signed [CW-1:0]     prox;
  logic signed [CW-1:0]     span_w;
  logic signed [CW-1:0]     quarter_w;
  logic signed [CW-1:0]     neg_w;
  logic                     above;
  logic                     adopt;
  logic [REPORT_W-1:0]      rep;
  logic [8:0]               lo;
  logic [8:0]               last_lo;
  logic [8:0]               tol;

  // The running sum replaces the entry at the slot, so the total costs one subtract and one add.
  always_comb begin
    sum_nxt = sum_r - SUM_W'(hist_r[slot]) + SUM_W'(value);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else if (ctrl.accept && !ctrl.in_load) begin
      hist_r[slot] <= value;
      sum_r        <= sum_nxt;
    end
  end

  // Floor of half the sum is an arithmetic shift; a load carries its baseline.
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      s1_val_r <= ctrl.in_load ? TOT_W'(value) : sum_nxt[SUM_W-1:1];
    end
  end

  always_comb begin
    tot_w     = CW'(s1_val_r);
    base_w    = CW'(base_r);
    span_w    = CW'(cfg.rise_span);
    quarter_w = CW'(cfg.rise_span[7:2]);
    neg_w     = CW'(cfg.negative_limit);
    diff      = tot_w - base_w;
    above     = !diff[CW-1] && (diff != '0);

    if ((wc_r == '0) || (peak_r < s1_val_r)) begin
      peak_cand = s1_val_r;
    end else begin
      peak_cand = peak_r;
    end
    peak_w = CW'(peak_cand);

    if (!above) begin
      wc_nxt = '0;
    end else if (wc_r < cfg.peak_window) begin
      wc_nxt = wc_r + COUNT_W'(1);
    end else begin
      wc_nxt = '0;
    end

    adopt = above && ((wc_nxt == '0) || (peak_w <= base_w + quarter_w)) &&
            (peak_w <= base_w + span_w);
    base1   = adopt ? peak_cand : base_r;
    base1_w = CW'(base1);
    prox    = tot_w - base1_w;

    // A deep negative excursion snaps the baseline to the current total.
    base_nxt = (prox < neg_w) ? s1_val_r : base1;
    peak_nxt = above ? peak_cand : peak_r;

    if (prox[CW-1]) begin
      rep = '0;
    end else if (prox > CW'(REPORT_MAX)) begin
      rep = REPORT_MAX;
    end else begin
      rep = prox[REPORT_W-1:0];
    end

    lo      = {1'b0, rep[7:0]};
    last_lo = {1'b0, last_r[7:0]};
    tol     = {1'b0, cfg.change_tolerance};

    if (ctrl.s1_load) begin
      report  = last_r;
      changed = 1'b0;
    end else begin
      report  = rep;
      changed = (rep[REPORT_W-1:8] != last_r[REPORT_W-1:8]) ||
                (lo + tol < last_lo) || (lo > last_lo + tol);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      peak_r <= '0;
      wc_r   <= '0;
      last_r <= '0;
    end else if (ctrl.fire) begin
      if (ctrl.s1_load) begin
        base_r <= s1_val_r;
      end else begin
        base_r <= base_nxt;
        peak_r <= peak_nxt;
        wc_r   <= wc_nxt;
        last_r <= rep;
      end
    end
  end

endmodule

// ----- rtl/core/pbt_merge.sv -----
// ============================================================================
// pbt_merge: result merge and output register
// Combines the lane change flags and holds the result until it is taken.
// ============================================================================
module pbt_merge import pbt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_valid,
  input  logic [REPORT_W-1:0] report_a,
  input  logic [REPORT_W-1:0] report_b,
  input  logic                changed_a,
  input  logic                changed_b,
  input  logic                out_stall,
  output logic                fire,
  output logic                out_valid,
  output logic [REPORT_W-1:0] out_proximity_a,
  output logic [REPORT_W-1:0] out_proximity_b,
  output logic                out_changed
);

  logic                out_valid_r;
  logic [REPORT_W-1:0] prox_a_r;
  logic [REPORT_W-1:0] prox_b_r;
  logic                changed_r;
  logic                out_ready;

  assign out_ready = !out_valid_r || !out_stall;
  assign fire      = s1_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      prox_a_r  <= report_a;
      prox_b_r  <= report_b;
      changed_r <= changed_a || changed_b;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_proximity_a = prox_a_r;
  assign out_proximity_b = prox_b_r;
  assign out_changed     = changed_r;

endmodule
